### rtl/core/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Types and constants shared by the motor reply deframer modules.
// ----------------------------------------------------------------------------
package mrd_pkg;

   localparam logic [7:0] HEAD_BYTE        = 8'h3E;
   localparam logic [7:0] CMD_STATUS_FIRST = 8'hA1;
   localparam logic [7:0] CMD_STATUS_LAST  = 8'hA8;
   localparam logic [7:0] CMD_ANGLE_MULTI  = 8'h92;
   localparam logic [7:0] CMD_ANGLE_SINGLE = 8'h94;

   // byte position within a frame, 0 means waiting for a head byte
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_IDLE    = 5'd0;
   localparam logic [POS_W-1:0] POS_CMD     = 5'd1;
   localparam logic [POS_W-1:0] POS_ID      = 5'd2;
   localparam logic [POS_W-1:0] POS_LEN     = 5'd3;
   localparam logic [POS_W-1:0] POS_HDR_SUM = 5'd4;
   localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd5;

   // only the first payload bytes are ever decoded
   localparam int PAYLOAD_KEEP = 8;
   localparam int PAY_IDX_W    = $clog2(PAYLOAD_KEEP);

   typedef enum logic [1:0] {
      STAT_GOOD     = 2'd0,
      STAT_HDR_SUM  = 2'd1,
      STAT_PAY_SUM  = 2'd2,
      STAT_TOO_LONG = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_OTHER        = 2'd0,
      KIND_STATUS       = 2'd1,
      KIND_MULTI_TURN   = 2'd2,
      KIND_SINGLE_TURN  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0]                         command;
      logic [7:0]                         device_id;
      logic [7:0]                         payload_length;
      logic [PAYLOAD_KEEP-1:0][7:0]       payload;
   } frame_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         command;
      logic [7:0]         device_id;
      logic [7:0]         payload_length;
      kind_type           reply_kind;
      logic signed [7:0]  temperature;
      logic signed [15:0] current_raw;
      logic signed [15:0] speed_raw;
      logic [15:0]        encoder_position;
      logic signed [63:0] angle_raw;
   } rsp_type;

endpackage

### rtl/core/mrd_decode.sv
// ----------------------------------------------------------------------------
// mrd_decode
// Turns the stored header and payload of a finished frame into result fields.
// ----------------------------------------------------------------------------
module mrd_decode (
   input  mrd_pkg::status_type status,
   input  mrd_pkg::frame_type  frame,
   output mrd_pkg::rsp_type    result
);
   import mrd_pkg::*;

   logic [PAYLOAD_KEEP-1:0][7:0] pay;

   // bytes beyond the received length read as zero
   always_comb begin
      for (int i = 0; i < PAYLOAD_KEEP; i++) begin
         pay[i] = (8'(i) < frame.payload_length) ? frame.payload[i] : 8'h00;
      end
   end

   always_comb begin
      result                  = '0;
      result.status           = status;
      result.command          = frame.command;
      result.device_id        = frame.device_id;
      result.payload_length   = frame.payload_length;
      result.reply_kind       = KIND_OTHER;
      if (status == STAT_GOOD) begin
         priority if (frame.command >= CMD_STATUS_FIRST &&
                      frame.command <= CMD_STATUS_LAST) begin
            result.reply_kind       = KIND_STATUS;
            result.temperature      = pay[0];
            result.current_raw      = {pay[2], pay[1]};
            result.speed_raw        = {pay[4], pay[3]};
            result.encoder_position = {pay[6], pay[5]};
         end else if (frame.command == CMD_ANGLE_MULTI) begin
            result.reply_kind = KIND_MULTI_TURN;
            result.angle_raw  = {pay[7], pay[6], pay[5], pay[4],
                                 pay[3], pay[2], pay[1], pay[0]};
         end else if (frame.command == CMD_ANGLE_SINGLE) begin
            result.reply_kind = KIND_SINGLE_TURN;
            result.angle_raw  = {32'h0, pay[3], pay[2], pay[1], pay[0]};
         end else begin
            result.reply_kind = KIND_OTHER;
         end
      end
   end

endmodule

### rtl/core/mrd_frame_ctrl.sv
// ----------------------------------------------------------------------------
// mrd_frame_ctrl
// Frame position tracking, running sum, header and payload storage.
// ----------------------------------------------------------------------------
module mrd_frame_ctrl #(
   parameter int MAX_FRAME = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output logic                emit,
   output mrd_pkg::status_type status,
   output mrd_pkg::frame_type  frame
);
   import mrd_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME - 6);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   frame_type        frame_ff, frame_in;
   logic [POS_W-1:0] pay_off;

   assign pay_off = pos_ff - POS_PAYLOAD;

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      frame_in = frame_ff;
      emit     = 1'b0;
      status   = STAT_GOOD;
      if (step) begin
         priority if (rx_byte == HEAD_BYTE) begin
            pos_in = POS_CMD;
            sum_in = HEAD_BYTE;
         end else if (pos_ff == POS_IDLE) begin
            pos_in = POS_IDLE;
         end else if (pos_ff <= POS_LEN) begin
            unique case (pos_ff)
               POS_CMD: frame_in.command        = rx_byte;
               POS_ID:  frame_in.device_id      = rx_byte;
               default: frame_in.payload_length = rx_byte;
            endcase
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + 5'd1;
         end else if (pos_ff == POS_HDR_SUM) begin
            pos_in = POS_IDLE;
            priority if (rx_byte != sum_ff) begin
               emit   = 1'b1;
               status = STAT_HDR_SUM;
            end else if (frame_ff.payload_length > MAX_LEN) begin
               emit   = 1'b1;
               status = STAT_TOO_LONG;
            end else begin
               sum_in = 8'h00;
               pos_in = POS_PAYLOAD;
            end
         end else if (9'(pos_ff) == 9'(frame_ff.payload_length) + 9'(POS_PAYLOAD)) begin
            // payload sum byte closes the frame
            pos_in = POS_IDLE;
            emit   = 1'b1;
            status = (rx_byte != sum_ff) ? STAT_PAY_SUM : STAT_GOOD;
         end else begin
            if (pay_off < 5'(PAYLOAD_KEEP)) begin
               frame_in.payload[pay_off[PAY_IDX_W-1:0]] = rx_byte;
            end
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_IDLE;
         sum_ff <= 8'h00;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame = frame_ff;

endmodule

### rtl/core/motor_reply_deframer.sv
// ----------------------------------------------------------------------------
// motor_reply_deframer
// Byte stream deframer for motor reply frames with additive checksums.
// ----------------------------------------------------------------------------
// Takes one received byte per word and gives at most one result per frame:
// after the payload sum byte, or right after a bad header sum or an oversize
// length. A 0x3E byte always restarts a frame. Each byte goes through an input
// register and then the framing and decode logic into the result register, so
// the block takes a byte every cycle while it does not stall. It stalls only
// while the result register holds a word that rsp_tready has not taken.
module motor_reply_deframer #(
   parameter int MAX_FRAME = 30
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // command, device_id, payload_length, temperature, current_raw,
   // speed_raw, encoder_position, angle_raw
   output logic [143:0] rsp_tdata,
   output logic [3:0]   rsp_tuser    // status, reply_kind
);
   import mrd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic       out_free;
   logic       step;
   logic       emit;
   status_type status;
   frame_type  frame;
   rsp_type    result;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   mrd_frame_ctrl #(
      .MAX_FRAME (MAX_FRAME)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .status  (status),
      .frame   (frame)
   );

   mrd_decode u_decode (
      .status (status),
      .frame  (frame),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (step && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.angle_raw, out_ff.encoder_position, out_ff.speed_raw,
                        out_ff.current_raw, out_ff.temperature, out_ff.payload_length,
                        out_ff.device_id, out_ff.command};
   assign rsp_tuser  = {out_ff.reply_kind, out_ff.status};

endmodule

### verif/motor_reply_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_reply_deframer_test
// Self-checking bench for the motor reply deframer.
// ----------------------------------------------------------------------------
// Feeds received bytes through the request stream and follows every accepted
// byte with a frame tracker of its own. The tracker predicts the reply words.
// Each reply word is checked field by field against the oldest prediction.
// Directed frames cover decoding, sum errors, oversize lengths and resync on
// the head byte. Random traffic then runs under three idle/stall mixes.
module motor_reply_deframer_test;
   import mrd_pkg::*;

   localparam int FRAME_MAX   = 30;
   localparam int CYCLE_LIMIT = 200000;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;   // rx_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // command, device_id, payload_length, temperature, current_raw,
   // speed_raw, encoder_position, angle_raw
   logic [143:0] rsp_tdata;
   logic [3:0]   rsp_tuser;            // status, reply_kind

   // frame tracker state
   logic [POS_W-1:0] frame_pos = POS_IDLE;
   logic [7:0]       frame_sum = 8'h00;
   logic [7:0]       frame_bytes [FRAME_MAX] = '{default: 8'h00};

   rsp_type expected_replies [$];
   int      replies_predicted = 0;
   int      bytes_accepted    = 0;
   int      mismatches        = 0;
   int      send_idle_pct     = 0;
   int      stall_pct         = 0;
   int      cycle_count       = 0;

   motor_reply_deframer #(
      .MAX_FRAME(FRAME_MAX)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // payload bytes beyond the received length decode as zero
   function automatic logic [7:0] payload_at(input int idx);
      if (idx < int'(frame_bytes[3])) return frame_bytes[5 + idx];
      return 8'h00;
   endfunction

   function automatic rsp_type build_reply(input status_type st, input bit decode);
      rsp_type    r;
      logic [7:0] cmd;
      int         k;
      r = '0;
      cmd = frame_bytes[1];
      r.status = st;
      r.command = cmd;
      r.device_id = frame_bytes[2];
      r.payload_length = frame_bytes[3];
      if (decode) begin
         if (cmd >= CMD_STATUS_FIRST && cmd <= CMD_STATUS_LAST) begin
            r.reply_kind = KIND_STATUS;
            r.temperature = payload_at(0);
            r.current_raw = {payload_at(2), payload_at(1)};
            r.speed_raw = {payload_at(4), payload_at(3)};
            r.encoder_position = {payload_at(6), payload_at(5)};
         end else if (cmd == CMD_ANGLE_MULTI) begin
            r.reply_kind = KIND_MULTI_TURN;
            for (k = 0; k < 8; k++) r.angle_raw[8*k +: 8] = payload_at(k);
         end else if (cmd == CMD_ANGLE_SINGLE) begin
            r.reply_kind = KIND_SINGLE_TURN;
            for (k = 0; k < 4; k++) r.angle_raw[8*k +: 8] = payload_at(k);
         end
      end
      return r;
   endfunction

   function automatic void queue_reply(input status_type st, input bit decode);
      expected_replies.push_back(build_reply(st, decode));
      replies_predicted++;
   endfunction

   // advances the frame tracker by one accepted byte
   function automatic void follow_frame(input logic [7:0] b);
      if (b == HEAD_BYTE) begin
         frame_bytes[0] = b;
         frame_sum = b;
         frame_pos = POS_CMD;
      end else if (frame_pos == POS_IDLE) begin
         // stray byte, nothing to do
      end else if (frame_pos <= POS_LEN) begin
         frame_bytes[frame_pos] = b;
         frame_sum += b;
         frame_pos++;
      end else if (frame_pos == POS_HDR_SUM) begin
         frame_pos = POS_IDLE;
         if (b != frame_sum) begin
            queue_reply(STAT_HDR_SUM, 1'b0);
         end else if (int'(frame_bytes[3]) > FRAME_MAX - 6) begin
            queue_reply(STAT_TOO_LONG, 1'b0);
         end else begin
            frame_sum = 8'h00;
            frame_pos = POS_PAYLOAD;
         end
      end else if (int'(frame_pos) == int'(frame_bytes[3]) + 5) begin
         frame_pos = POS_IDLE;
         if (b != frame_sum) queue_reply(STAT_PAY_SUM, 1'b0);
         else queue_reply(STAT_GOOD, 1'b1);
      end else begin
         if (int'(frame_pos) < FRAME_MAX) frame_bytes[frame_pos] = b;
         frame_sum += b;
         frame_pos++;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_accepted++;
      follow_frame(b);
   endtask

   // a nonzero error mask flips bits of the matching sum byte
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] id,
                             input logic [7:0] len, input logic [7:0] body [$],
                             input logic [7:0] hdr_err = 8'h00,
                             input logic [7:0] pay_err = 8'h00);
      logic [7:0] sum;
      sum = HEAD_BYTE + cmd + id + len;
      send_byte(HEAD_BYTE);
      send_byte(cmd);
      send_byte(id);
      send_byte(len);
      send_byte(sum ^ hdr_err);
      sum = 8'h00;
      foreach (body[i]) begin
         send_byte(body[i]);
         sum += body[i];
      end
      send_byte(sum ^ pay_err);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == HEAD_BYTE);
      return b;
   endfunction

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_reply_decoding();
      logic [7:0] body [$];
      int         i;
      body = '{8'h80, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF};
      send_frame(CMD_STATUS_FIRST, 8'h01, 8'd7, body);
      body = '{8'h7F, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00};
      send_frame(CMD_STATUS_LAST, 8'hFF, 8'd7, body);
      body = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
      send_frame(CMD_ANGLE_MULTI, 8'h00, 8'd8, body);
      body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame(CMD_ANGLE_SINGLE, 8'h03, 8'd4, body);
      // short payloads leave the upper bytes at zero
      body = '{8'h9C, 8'h82};
      send_frame(8'hA4, 8'h04, 8'd2, body);
      body = '{8'h11, 8'h22, 8'h83};
      send_frame(CMD_ANGLE_MULTI, 8'h05, 8'd3, body);
      body = '{};
      send_frame(8'h55, 8'hFF, 8'd0, body);
      // commands just outside the status range, and 0x93 between the angle commands, decode as other
      body = '{8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70};
      send_frame(8'hA0, 8'h06, 8'd7, body);
      send_frame(8'hA9, 8'h07, 8'd7, body);
      body = '{8'h12, 8'h34, 8'h56, 8'h78};
      send_frame(8'h93, 8'h08, 8'd4, body);
      body = '{};
      for (i = 0; i < FRAME_MAX - 6; i++) body.push_back(8'(8'hC0 + 5 * i));
      send_frame(CMD_ANGLE_SINGLE, 8'h09, 8'(FRAME_MAX - 6), body);
   endtask

   task automatic test_frame_errors();
      logic [7:0] body [$];
      body = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07};
      send_frame(8'hA1, 8'h01, 8'd7, body, 8'h01);
      send_frame(8'hA3, 8'h08, 8'd7, body, 8'h00, 8'h01);
      body = '{};
      // header sum is checked before the length
      send_frame(8'hA1, 8'h01, 8'(FRAME_MAX - 5), body, 8'h80);
      send_frame(8'hA2, 8'h06, 8'(FRAME_MAX - 5), body);
      send_frame(CMD_ANGLE_MULTI, 8'h07, 8'hFF, body);
      send_frame(8'h55, 8'h09, 8'd0, body, 8'h00, 8'hFF);
   endtask

   task automatic test_resync();
      logic [7:0] body [$];
      body = '{8'h21, 8'h43, 8'h65, 8'h87, 8'hA9, 8'hCB, 8'hED};
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA1);
      send_frame(8'hA5, 8'h0A, 8'd7, body);
      // head byte inside the payload
      send_byte(HEAD_BYTE);
      send_byte(8'hA1);
      send_byte(8'h01);
      send_byte(8'h07);
      send_byte(8'hE7);
      send_byte(8'h10);
      send_byte(8'h20);
      send_frame(8'hA6, 8'h0B, 8'd7, body);
      // head byte where the header sum belongs
      send_byte(HEAD_BYTE);
      send_byte(CMD_ANGLE_MULTI);
      send_byte(8'h01);
      send_byte(8'h08);
      send_frame(8'hA7, 8'h0C, 8'd7, body);
      // head byte where the payload sum belongs
      send_byte(HEAD_BYTE);
      send_byte(CMD_ANGLE_SINGLE);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'hD3);
      // head byte as the command
      send_byte(HEAD_BYTE);
      send_frame(8'hA2, 8'h0D, 8'd7, body);
   endtask

   task automatic send_random_frame();
      logic [7:0] cmd;
      logic [7:0] id;
      logic [7:0] len;
      logic [7:0] hdr_err;
      logic [7:0] pay_err;
      logic [7:0] body [$];
      int         pick;
      int         i;
      pick = $urandom_range(9);
      if (pick < 4) begin
         cmd = 8'(CMD_STATUS_FIRST + $urandom_range(7));
         len = 8'd7;
      end else if (pick == 4) begin
         cmd = CMD_ANGLE_MULTI;
         len = 8'd8;
      end else if (pick == 5) begin
         cmd = CMD_ANGLE_SINGLE;
         len = 8'd4;
      end else begin
         cmd = plain_byte();
         len = 8'($urandom_range(FRAME_MAX - 6));
      end
      pick = $urandom_range(19);
      if (pick < 5) len = 8'($urandom_range(FRAME_MAX - 6));
      else if (pick == 5) len = 8'($urandom_range(255, FRAME_MAX - 5));
      id = plain_byte();
      body = '{};
      if (int'(len) <= FRAME_MAX - 6)
         for (i = 0; i < int'(len); i++) body.push_back(plain_byte());
      hdr_err = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
      pay_err = ($urandom_range(14) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
      send_frame(cmd, id, len, body, hdr_err, pay_err);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int rsp_stall_pct,
                                      input int byte_count);
      int byte_goal;
      int reply_goal;
      int n;
      send_idle_pct = idle_pct;
      stall_pct = rsp_stall_pct;
      byte_goal = bytes_accepted + byte_count;
      reply_goal = replies_predicted + 6;
      while (bytes_accepted < byte_goal || replies_predicted < reply_goal) begin
         if ($urandom_range(9) == 0) begin
            // line noise, may also leave a broken frame behind
            for (n = $urandom_range(3, 1); n > 0; n--) send_byte(8'($urandom_range(255)));
         end else begin
            send_random_frame();
         end
      end
      drain_replies();
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : reply_check
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               $error("reply word with no frame pending: %h / %h", rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               check_field("status", want.status, rsp_tuser[1:0]);
               check_field("reply_kind", want.reply_kind, rsp_tuser[3:2]);
               check_field("command", want.command, rsp_tdata[7:0]);
               check_field("device_id", want.device_id, rsp_tdata[15:8]);
               check_field("payload_length", want.payload_length, rsp_tdata[23:16]);
               check_field("temperature", $unsigned(want.temperature), rsp_tdata[31:24]);
               check_field("current_raw", $unsigned(want.current_raw), rsp_tdata[47:32]);
               check_field("speed_raw", $unsigned(want.speed_raw), rsp_tdata[63:48]);
               check_field("encoder_position", want.encoder_position, rsp_tdata[79:64]);
               check_field("angle_raw", $unsigned(want.angle_raw), rsp_tdata[143:80]);
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("motor_reply_deframer_test failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 25;
      stall_pct = 76;
      test_reply_decoding();
      test_frame_errors();
      test_resync();
      drain_replies();
      test_random_traffic(25, 76, 80);
      test_random_traffic(76, 25, 80);
      test_random_traffic(0, 0, 80);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("motor_reply_deframer_test passed");
      end else begin
         $display("motor_reply_deframer_test failed");
      end
      $finish;
   end

endmodule
